FILE: sv/tekd_pkg.sv
// ============================================================================
// tekd_pkg
// Types and byte constants shared by the terminal escape key decoder.
// ============================================================================
`default_nettype none

package tekd_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_FIRST   = 4'd1,
        PH_BRACKET = 4'd2,
        PH_SS3     = 4'd3,
        PH_OTHER   = 4'd4,
        PH_DIGIT   = 4'd5,
        PH_MBUTTON = 4'd6,
        PH_MPOS1   = 4'd7,
        PH_MPOS2   = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        KEY_PLAIN = 4'd0,
        KEY_ESC   = 4'd1,
        KEY_UP    = 4'd2,
        KEY_DOWN  = 4'd3,
        KEY_RIGHT = 4'd4,
        KEY_LEFT  = 4'd5,
        KEY_HOME  = 4'd6,
        KEY_END   = 4'd7,
        KEY_DEL   = 4'd8,
        KEY_PGUP  = 4'd9,
        KEY_PGDN  = 4'd10
    } t_key_kind;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_TICK = 1'b1
    } t_action;

    localparam logic [7:0] C_ESC      = 8'd27;
    localparam logic [7:0] C_LBRACKET = 8'h5B;
    localparam logic [7:0] C_SS3      = 8'h4F;
    localparam logic [7:0] C_TILDE    = 8'h7E;
    localparam logic [7:0] C_MOUSE    = 8'h4D;
    localparam logic [7:0] C_BTN_DOWN = 8'h61;
    localparam logic [7:0] C_BTN_UP   = 8'h60;
    localparam logic [7:0] C_DIGIT_0  = 8'h30;
    localparam logic [7:0] C_DIGIT_9  = 8'h39;
    localparam logic [7:0] C_DIGIT_3  = 8'h33;
    localparam logic [7:0] C_DIGIT_5  = 8'h35;
    localparam logic [7:0] C_DIGIT_6  = 8'h36;
    localparam logic [7:0] C_UP       = 8'h41;
    localparam logic [7:0] C_DOWN     = 8'h42;
    localparam logic [7:0] C_RIGHT    = 8'h43;
    localparam logic [7:0] C_LEFT     = 8'h44;
    localparam logic [7:0] C_HOME     = 8'h48;
    localparam logic [7:0] C_END      = 8'h46;

endpackage

`default_nettype wire

FILE: sv/terminal_escape_key_decoder_unit.sv
// ============================================================================
// terminal_escape_key_decoder_unit
// Decodes terminal bytes and read timeout ticks into key codes.
// ============================================================================
//
//   channel  direction  handshake               word
//   -------  ---------  ----------------------  ----------------------------
//   input    in         i_in_valid / o_in_stall  i_action, i_data_byte
//   output   out        o_out_valid / i_out_stall o_key_kind, o_char_byte
//
// One word is accepted every cycle unless the input is stalled, and a key that
// it completes appears in the output register on the next cycle.
// The parser state and the output register decide the rate: one transition
// per word. Reset (synchronous, active low) returns the parser to idle and
// empties the output register. The input stalls only while the output
// register holds a key that is itself stalled.
`default_nettype none

module terminal_escape_key_decoder_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_action,
    input  wire logic [7:0] i_data_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [3:0]      o_key_kind,
    output logic [7:0]      o_char_byte
);
    import tekd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_digit, n_digit;
    logic [7:0] r_button, n_button;
    logic       r_out_valid;
    t_key_kind  r_kind;
    logic [7:0] r_char;

    logic       accept;
    logic       tick;
    logic       emit;
    t_key_kind  emit_kind;
    logic [7:0] emit_char;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign tick       = (i_action == ACT_TICK);

    always_comb begin
        n_phase  = r_phase;
        n_digit  = r_digit;
        n_button = r_button;
        case (r_phase)
            PH_IDLE: begin
                if (!tick && i_data_byte == C_ESC) begin
                    n_phase = PH_FIRST;
                end else if (!tick) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_MPOS1: begin
                if (tick) begin
                    n_phase = (r_button == C_BTN_DOWN || r_button == C_BTN_UP)
                              ? PH_IDLE : PH_FIRST;
                end else begin
                    n_phase = PH_MPOS2;
                end
            end
            PH_MPOS2: begin
                n_phase = (r_button == C_BTN_DOWN || r_button == C_BTN_UP)
                          ? PH_IDLE : PH_FIRST;
            end
            PH_FIRST: begin
                if (tick) begin
                    n_phase = PH_IDLE;
                end else if (i_data_byte == C_LBRACKET) begin
                    n_phase = PH_BRACKET;
                end else if (i_data_byte == C_SS3) begin
                    n_phase = PH_SS3;
                end else begin
                    n_phase = PH_OTHER;
                end
            end
            PH_BRACKET: begin
                if (tick) begin
                    n_phase = PH_IDLE;
                end else if (i_data_byte inside {[C_DIGIT_0:C_DIGIT_9]}) begin
                    n_digit = i_data_byte;
                    n_phase = PH_DIGIT;
                end else if (i_data_byte inside {C_UP, C_DOWN, C_RIGHT, C_LEFT,
                                                 C_HOME, C_END}) begin
                    n_phase = PH_IDLE;
                end else if (i_data_byte == C_MOUSE) begin
                    n_phase = PH_MBUTTON;
                end else begin
                    n_phase = PH_FIRST;
                end
            end
            PH_DIGIT: begin
                if (tick) begin
                    n_phase = PH_IDLE;
                end else if (i_data_byte == C_TILDE &&
                             r_digit inside {C_DIGIT_3, C_DIGIT_5, C_DIGIT_6}) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_FIRST;
                end
            end
            PH_SS3: begin
                if (tick) begin
                    n_phase = PH_IDLE;
                end else if (i_data_byte inside {C_HOME, C_END}) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_FIRST;
                end
            end
            PH_OTHER: begin
                n_phase = tick ? PH_IDLE : PH_FIRST;
            end
            PH_MBUTTON: begin
                if (tick) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_button = i_data_byte;
                    n_phase  = PH_MPOS1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        emit      = 1'b0;
        emit_kind = KEY_PLAIN;
        emit_char = 8'd0;
        case (r_phase)
            PH_IDLE: begin
                if (!tick && i_data_byte != C_ESC) begin
                    emit      = 1'b1;
                    emit_char = i_data_byte;
                end
            end
            PH_MPOS1, PH_MPOS2: begin
                if (r_phase == PH_MPOS2 || tick) begin
                    if (r_button == C_BTN_DOWN) begin
                        emit      = 1'b1;
                        emit_kind = KEY_DOWN;
                    end else if (r_button == C_BTN_UP) begin
                        emit      = 1'b1;
                        emit_kind = KEY_UP;
                    end
                end
            end
            PH_FIRST, PH_OTHER, PH_MBUTTON: begin
                if (tick) begin
                    emit      = 1'b1;
                    emit_kind = KEY_ESC;
                end
            end
            PH_BRACKET: begin
                if (tick) begin
                    emit      = 1'b1;
                    emit_kind = KEY_ESC;
                end else begin
                    emit = 1'b1;
                    case (i_data_byte)
                        C_UP:    emit_kind = KEY_UP;
                        C_DOWN:  emit_kind = KEY_DOWN;
                        C_RIGHT: emit_kind = KEY_RIGHT;
                        C_LEFT:  emit_kind = KEY_LEFT;
                        C_HOME:  emit_kind = KEY_HOME;
                        C_END:   emit_kind = KEY_END;
                        default: emit      = 1'b0;
                    endcase
                end
            end
            PH_DIGIT: begin
                if (tick) begin
                    emit      = 1'b1;
                    emit_kind = KEY_ESC;
                end else if (i_data_byte == C_TILDE) begin
                    emit = 1'b1;
                    case (r_digit)
                        C_DIGIT_3: emit_kind = KEY_DEL;
                        C_DIGIT_5: emit_kind = KEY_PGUP;
                        C_DIGIT_6: emit_kind = KEY_PGDN;
                        default:   emit      = 1'b0;
                    endcase
                end
            end
            PH_SS3: begin
                if (tick) begin
                    emit      = 1'b1;
                    emit_kind = KEY_ESC;
                end else if (i_data_byte == C_HOME) begin
                    emit      = 1'b1;
                    emit_kind = KEY_HOME;
                end else if (i_data_byte == C_END) begin
                    emit      = 1'b1;
                    emit_kind = KEY_END;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_digit     <= 8'd0;
            r_button    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_digit  <= n_digit;
                r_button <= n_button;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_kind <= emit_kind;
            r_char <= emit_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_kind  = r_kind;
    assign o_char_byte = r_char;

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != KEY_PLAIN) |-> (r_char == 8'd0))
        else $error("char byte is not zero for a decoded key");

    a_plain_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_IDLE && !tick && i_data_byte != C_ESC)
        |=> (r_out_valid && r_kind == KEY_PLAIN && r_char == $past(i_data_byte)))
        else $error("plain byte was not passed through");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled while the output register can take a key");

    a_mpos2_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_MPOS1 && !tick) |=> (r_phase == PH_MPOS2))
        else $error("second mouse position byte not reached");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ============================================================================
// tb
// Self-checking testbench for the terminal escape key decoder. A behavioral
// predictor tracks the parser and queues the keys it expects. A checker
// compares each accepted output word with the oldest queued key. Stimulus is
// directed key sequences, then mostly well-formed random sequences and noise
// under random idling on both channels, a long output hold, a steady stream.
// ============================================================================

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tekd_pkg::*;

    localparam int LONG_HOLD_CYCLES = 150;
    localparam int RANDOM_WORDS     = 1250;

    typedef struct {
        t_key_kind  kind;
        logic [7:0] ch;
    } t_decoded_key;

    logic       i_clk;
    logic       rst_n;
    logic       in_valid;
    t_action    in_action;
    logic [7:0] in_byte;
    logic       out_stall;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [3:0] o_key_kind;
    logic [7:0] o_char_byte;

    t_decoded_key pending_keys[$];
    t_decoded_key head_key;

    t_phase     pred_phase;
    logic [7:0] pred_digit;
    logic [7:0] pred_button;

    bit in_gaps;
    bit stall_bursts;
    bit hold_request;
    int words_sent;
    int ticks_sent;
    int keys_checked;
    int mismatch_count;

    terminal_escape_key_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (in_action),
        .i_data_byte (in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_key_kind  (o_key_kind),
        .o_char_byte (o_char_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 25) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic expect_key(input t_key_kind kind, input logic [7:0] ch);
        t_decoded_key k;
        k.kind = kind;
        k.ch = ch;
        pending_keys.push_back(k);
        pred_phase = PH_IDLE;
    endtask

    task automatic finish_mouse_report();
        if (pred_button == C_BTN_DOWN) begin
            expect_key(KEY_DOWN, 8'h00);
        end else if (pred_button == C_BTN_UP) begin
            expect_key(KEY_UP, 8'h00);
        end else begin
            pred_phase = PH_FIRST;
        end
    endtask

    task automatic decode_predict(input t_action act, input logic [7:0] b);
        logic tick;
        tick = (act == ACT_TICK);
        if (pred_phase == PH_IDLE) begin
            if (!tick) begin
                if (b == C_ESC) begin
                    pred_phase = PH_FIRST;
                end else begin
                    expect_key(KEY_PLAIN, b);
                end
            end
        end else if (pred_phase == PH_MPOS1) begin
            if (tick) begin
                finish_mouse_report();
            end else begin
                pred_phase = PH_MPOS2;
            end
        end else if (pred_phase == PH_MPOS2) begin
            finish_mouse_report();
        end else if (tick) begin
            expect_key(KEY_ESC, 8'h00);
        end else begin
            case (pred_phase)
                PH_FIRST: begin
                    if (b == C_LBRACKET) begin
                        pred_phase = PH_BRACKET;
                    end else if (b == C_SS3) begin
                        pred_phase = PH_SS3;
                    end else begin
                        pred_phase = PH_OTHER;
                    end
                end
                PH_BRACKET: begin
                    if (b >= C_DIGIT_0 && b <= C_DIGIT_9) begin
                        pred_digit = b;
                        pred_phase = PH_DIGIT;
                    end else begin
                        case (b)
                            C_UP:    expect_key(KEY_UP, 8'h00);
                            C_DOWN:  expect_key(KEY_DOWN, 8'h00);
                            C_RIGHT: expect_key(KEY_RIGHT, 8'h00);
                            C_LEFT:  expect_key(KEY_LEFT, 8'h00);
                            C_HOME:  expect_key(KEY_HOME, 8'h00);
                            C_END:   expect_key(KEY_END, 8'h00);
                            C_MOUSE: pred_phase = PH_MBUTTON;
                            default: pred_phase = PH_FIRST;
                        endcase
                    end
                end
                PH_DIGIT: begin
                    if (b == C_TILDE && pred_digit == C_DIGIT_3) begin
                        expect_key(KEY_DEL, 8'h00);
                    end else if (b == C_TILDE && pred_digit == C_DIGIT_5) begin
                        expect_key(KEY_PGUP, 8'h00);
                    end else if (b == C_TILDE && pred_digit == C_DIGIT_6) begin
                        expect_key(KEY_PGDN, 8'h00);
                    end else begin
                        pred_phase = PH_FIRST;
                    end
                end
                PH_SS3: begin
                    if (b == C_HOME) begin
                        expect_key(KEY_HOME, 8'h00);
                    end else if (b == C_END) begin
                        expect_key(KEY_END, 8'h00);
                    end else begin
                        pred_phase = PH_FIRST;
                    end
                end
                PH_OTHER: pred_phase = PH_FIRST;
                PH_MBUTTON: begin
                    pred_button = b;
                    pred_phase = PH_MPOS1;
                end
                default: pred_phase = PH_IDLE;
            endcase
        end
    endtask

    task automatic send_word(input t_action act, input logic [7:0] b);
        @(negedge i_clk);
        if (in_gaps && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_byte   <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        decode_predict(act, b);
        words_sent++;
        if (act == ACT_TICK) begin
            ticks_sent++;
        end
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        send_word(ACT_BYTE, b);
    endtask

    task automatic send_tick();
        send_word(ACT_TICK, rand_byte());
    endtask

    // Inside a sequence a timeout occasionally replaces the next byte.
    task automatic send_seq_byte(input logic [7:0] b);
        if ($urandom_range(0, 24) == 0) begin
            send_tick();
        end else begin
            send_byte(b);
        end
    endtask

    function automatic logic [7:0] pick_csi_final();
        case ($urandom_range(0, 6))
            0:       return C_UP;
            1:       return C_DOWN;
            2:       return C_RIGHT;
            3:       return C_LEFT;
            4:       return C_HOME;
            5:       return C_END;
            default: return rand_byte();
        endcase
    endfunction

    function automatic logic [7:0] pick_edit_digit();
        case ($urandom_range(0, 4))
            0:       return C_DIGIT_3;
            1:       return C_DIGIT_5;
            2:       return C_DIGIT_6;
            default: return 8'(C_DIGIT_0 + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] pick_mouse_button();
        case ($urandom_range(0, 4))
            0, 1:    return C_BTN_DOWN;
            2, 3:    return C_BTN_UP;
            default: return rand_byte();
        endcase
    endfunction

    task automatic send_random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            send_byte(rand_byte());
        end else if (pick < 20) begin
            send_tick();
        end else if (pick < 26) begin
            send_byte(C_ESC);
            send_tick();
        end else begin
            send_byte(C_ESC);
            if (pick < 46) begin
                send_seq_byte(C_LBRACKET);
                send_seq_byte(pick_csi_final());
            end else if (pick < 62) begin
                send_seq_byte(C_LBRACKET);
                send_seq_byte(pick_edit_digit());
                send_seq_byte(($urandom_range(0, 6) != 0) ? C_TILDE : rand_byte());
            end else if (pick < 72) begin
                send_seq_byte(C_SS3);
                case ($urandom_range(0, 4))
                    0, 1:    send_seq_byte(C_HOME);
                    2, 3:    send_seq_byte(C_END);
                    default: send_seq_byte(rand_byte());
                endcase
            end else if (pick < 90) begin
                send_seq_byte(C_LBRACKET);
                send_seq_byte(C_MOUSE);
                send_seq_byte(pick_mouse_button());
                if ($urandom_range(0, 6) == 0) begin
                    send_tick();
                end else begin
                    send_byte(rand_byte());
                    if ($urandom_range(0, 6) == 0) begin
                        send_tick();
                    end else begin
                        send_byte(rand_byte());
                    end
                end
            end else begin
                send_byte(rand_byte());
                send_byte(rand_byte());
            end
        end
    endtask

    task automatic test_plain_and_idle_tick();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_tick();
    endtask

    task automatic test_cursor_and_edit_keys();
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        send_byte(C_UP);
        send_byte(C_ESC);
        send_byte(C_SS3);
        send_byte(C_END);
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        send_byte(C_DIGIT_5);
        send_byte(C_TILDE);
    endtask

    task automatic test_mouse_reports();
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        send_byte(C_MOUSE);
        send_byte(C_BTN_UP);
        send_tick();
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        send_byte(C_MOUSE);
        send_byte(C_BTN_DOWN);
        send_byte(8'h21);
        send_tick();
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        send_byte(C_MOUSE);
        send_byte(8'h7A);
        send_tick();
        send_tick();
    endtask

    task automatic test_broken_sequences();
        send_byte(C_ESC);
        send_byte(8'h71);
        send_byte(8'h72);
        send_byte(C_LBRACKET);
        send_byte(8'h34);
        send_byte(C_TILDE);
        send_tick();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        stop_at = words_sent + RANDOM_WORDS;
        in_gaps = 1'b1;
        stall_bursts = 1'b1;
        while (words_sent < stop_at) begin
            send_random_sequence();
        end
    endtask

    task automatic test_output_backpressure();
        logic [7:0] b;
        in_gaps = 1'b0;
        stall_bursts = 1'b0;
        send_tick();
        send_tick();
        hold_request = 1'b1;
        repeat (40) begin
            b = rand_byte();
            send_byte((b == C_ESC) ? 8'h20 : b);
        end
    endtask

    task automatic test_steady_stream();
        int stop_at;
        stop_at = words_sent + 60;
        in_gaps = 1'b0;
        stall_bursts = 1'b0;
        while (words_sent < stop_at) begin
            send_random_sequence();
        end
    endtask

    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                out_stall <= 1'b0;
            end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_keys.size() == 0) begin
                flag_mismatch($sformatf("unexpected key kind %0d char %02h",
                                        o_key_kind, o_char_byte));
            end else begin
                head_key = pending_keys.pop_front();
                keys_checked++;
                if (o_key_kind !== head_key.kind) begin
                    flag_mismatch($sformatf("key kind %0d, expected %0d",
                                            o_key_kind, head_key.kind));
                end
                if (o_char_byte !== head_key.ch) begin
                    flag_mismatch($sformatf("char byte %02h, expected %02h",
                                            o_char_byte, head_key.ch));
                end
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_action = ACT_BYTE;
        in_byte = 8'h00;
        in_gaps = 1'b0;
        stall_bursts = 1'b0;
        hold_request = 1'b0;
        words_sent = 0;
        ticks_sent = 0;
        keys_checked = 0;
        mismatch_count = 0;
        pred_phase = PH_IDLE;
        pred_digit = 8'h00;
        pred_button = 8'h00;
        repeat (2) @(negedge i_clk);
        rst_n <= 1'b1;

        test_plain_and_idle_tick();
        test_cursor_and_edit_keys();
        test_mouse_reports();
        test_broken_sequences();
        test_random_traffic();
        test_output_backpressure();
        test_steady_stream();

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_keys.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d input words (%0d timeout ticks) and checked %0d decoded keys,",
                 words_sent, ticks_sent, keys_checked);
        $display("including a %0d-cycle output hold that backed up the input.",
                 LONG_HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/tekd_pkg.sv
sv/terminal_escape_key_decoder_unit.sv
tb/tb.sv
